// ===== rtl/core/bfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned MaxBlocks = 32;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned SizeW     = 16;
  localparam int unsigned NumW      = 6;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [SizeW-1:0] size_t;
  typedef logic [NumW-1:0]  num_t;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpAlloc = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  // table access from the controller
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    size_t wdata;
    logic  re;
    idx_t  raddr;
  } tbl_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/bfa_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_table
// Block size table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfa_table (
  input  wire               clk_i,
  input  bfa_pkg::tbl_req_t req_i,
  output bfa_pkg::size_t    rdata_o
);
  import bfa_pkg::*;

  size_t mem_q [MaxBlocks];
  size_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/best_fit_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a table of block sizes held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start_i is high and busy_o is low. A load item
//   (opcode 0) writes size_i to table entry entry_index_i and frees that
//   entry; it gives no result and leaves busy_o low.
//   A request item (opcode 1) scans entries 0 .. N-1, N = min(num_blocks, 32),
//   reading one entry per cycle from the table RAM. The item occupies the
//   block through accept, the N reads and the final compare; the result is
//   shown on the following cycle with done_o high for exactly one cycle, and
//   a new item may be started in that same cycle. The table has a single read
//   port, hence the serial scan. num_blocks is written with cfg_we_i /
//   cfg_wdata_i; the user must do so only while idle, which the block does not
//   enforce. Reset clears all used marks, num_blocks and the controller; the
//   table contents are undefined until loaded. Results cannot be stalled.
// ----------------------------------------------------------------------------
module best_fit_block_allocator (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  output logic            busy_o,
  input  wire             opcode_i,
  input  bfa_pkg::idx_t   entry_index_i,
  input  bfa_pkg::size_t  size_i,
  input  wire             cfg_we_i,
  input  bfa_pkg::num_t   cfg_wdata_i,
  output logic            done_o,
  output logic            granted_o,
  output bfa_pkg::idx_t   block_index_o,
  output bfa_pkg::size_t  block_size_o,
  output bfa_pkg::size_t  fragment_o
);
  import bfa_pkg::*;

  state_e   state_q, state_d;
  num_t     num_blocks_q;
  size_t    size_q;
  idx_t     cnt_q, last_q;
  logic     cmp_v_q;
  idx_t     cmp_idx_q;
  logic     best_found_q;
  idx_t     best_idx_q;
  size_t    best_size_q, best_rem_q;
  logic [MaxBlocks-1:0] used_q;
  logic     done_q, granted_q;
  idx_t     out_idx_q;
  size_t    out_size_q, out_frag_q;

  tbl_req_t tbl_req;
  size_t    rdata;
  num_t     lim;
  idx_t     last_d;
  logic     accept, take_alloc, take_load;
  logic     cand_fit, take;
  size_t    cand_rem;
  logic     nxt_found;
  idx_t     nxt_idx;
  size_t    nxt_size, nxt_rem;

  bfa_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (rdata)
  );

  assign accept     = start_i && (state_q == StIdle);
  assign take_alloc = accept && (opcode_e'(opcode_i) == OpAlloc);
  assign take_load  = accept && (opcode_e'(opcode_i) == OpLoad);

  assign lim    = (num_blocks_q > NumW'(MaxBlocks)) ? NumW'(MaxBlocks) : num_blocks_q;
  assign last_d = IdxW'(lim - NumW'(1));

  // compare of the entry read last cycle against the best so far
  assign cand_fit  = cmp_v_q && !used_q[cmp_idx_q] && (rdata >= size_q);
  assign cand_rem  = rdata - size_q;
  assign take      = cand_fit && (!best_found_q || (cand_rem < best_rem_q));
  assign nxt_found = best_found_q | take;
  assign nxt_idx   = take ? cmp_idx_q : best_idx_q;
  assign nxt_size  = take ? rdata     : best_size_q;
  assign nxt_rem   = take ? cand_rem  : best_rem_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (take_alloc) begin
          state_d = (lim == '0) ? StFinish : StScan;
        end
      end
      StScan: begin
        if (cnt_q == last_q) begin
          state_d = StFinish;
        end
      end
      StFinish: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    tbl_req       = '0;
    tbl_req.we    = take_load;
    tbl_req.waddr = entry_index_i;
    tbl_req.wdata = size_i;
    tbl_req.re    = (state_q == StScan);
    tbl_req.raddr = cnt_q;
    busy_o        = (state_q != StIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      num_blocks_q <= '0;
      used_q       <= '0;
      cmp_v_q      <= 1'b0;
      best_found_q <= 1'b0;
      done_q       <= 1'b0;
      granted_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StFinish);
      cmp_v_q <= (state_q == StScan);
      if (cfg_we_i) begin
        num_blocks_q <= cfg_wdata_i;
      end
      if (take_load) begin
        used_q[entry_index_i] <= 1'b0;
      end
      if (take_alloc) begin
        best_found_q <= 1'b0;
      end else begin
        best_found_q <= nxt_found;
      end
      if (state_q == StFinish) begin
        granted_q <= nxt_found;
        if (nxt_found) begin
          used_q[nxt_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cnt_q;
    best_idx_q  <= nxt_idx;
    best_size_q <= nxt_size;
    best_rem_q  <= nxt_rem;
    if (take_alloc) begin
      size_q <= size_i;
      cnt_q  <= '0;
      last_q <= last_d;
    end else if (state_q == StScan) begin
      cnt_q <= cnt_q + IdxW'(1);
    end
    if (state_q == StFinish) begin
      out_idx_q  <= nxt_found ? nxt_idx  : '0;
      out_size_q <= nxt_found ? nxt_size : '0;
      out_frag_q <= nxt_found ? nxt_rem  : '0;
    end
  end

  assign done_o        = done_q;
  assign granted_o     = granted_q;
  assign block_index_o = out_idx_q;
  assign block_size_o  = out_size_q;
  assign fragment_o    = out_frag_q;

endmodule
`default_nettype wire

// ===== tb/tb_best_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_block_allocator
// Self-checking bench for the best-fit allocator. Loads fill the size table,
// requests are checked grant by grant against a behavioural best-fit search
// kept in the bench, across several num_blocks settings.
// ----------------------------------------------------------------------------
module tb_best_fit_block_allocator;
  import bfa_pkg::*;

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned MaxReports = 40;

  typedef struct packed {
    opcode_e op;
    idx_t    entry;
    size_t   size;
  } item_t;

  typedef struct packed {
    logic  granted;
    idx_t  index;
    size_t bsize;
    size_t frag;
  } grant_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  opcode_e opcode = OpLoad;
  idx_t    entry_index = '0;
  size_t   size = '0;
  logic    cfg_we = 1'b0;
  num_t    cfg_wdata = '0;
  logic    busy;
  logic    done;
  logic    granted;
  idx_t    block_index;
  size_t   block_size;
  size_t   fragment;

  item_t       item_q[$];
  grant_t      grant_q[$];
  size_t       blk_size[MaxBlocks];
  logic        blk_used[MaxBlocks];
  num_t        num_cfg = '0;
  bit          took = 1'b0;
  bit          calm = 1'b0;
  int unsigned errors = 0;
  int unsigned quiet = 0;
  item_t       cur_item;
  int unsigned plan[8] = '{1, 32, 63, 2, 17, 33, 0, 32};

  best_fit_block_allocator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .opcode_i      (opcode),
    .entry_index_i (entry_index),
    .size_i        (size),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .done_o        (done),
    .granted_o     (granted),
    .block_index_o (block_index),
    .block_size_o  (block_size),
    .fragment_o    (fragment)
  );

  always #1 clk = ~clk;

  function automatic size_t pick_size();
    case ($urandom_range(7))
      0: return size_t'($urandom_range(65535));
      1: return size_t'(16'hFFFF - $urandom_range(15));
      default: return size_t'($urandom_range(511));
    endcase
  endfunction

  // best-fit search over the bench's copy of the table
  function automatic void place_item(item_t it);
    int unsigned limit;
    bit          found;
    int unsigned best;
    size_t       rem_best;
    grant_t      g;
    if (it.op == OpLoad) begin
      blk_size[it.entry] = it.size;
      blk_used[it.entry] = 1'b0;
      return;
    end
    limit = (num_cfg > MaxBlocks) ? MaxBlocks : num_cfg;
    found = 1'b0;
    best = 0;
    rem_best = '0;
    for (int unsigned j = 0; j < limit; j++) begin
      if (!blk_used[j] && blk_size[j] >= it.size) begin
        if (!found || size_t'(blk_size[j] - it.size) < rem_best) begin
          found = 1'b1;
          best = j;
          rem_best = blk_size[j] - it.size;
        end
      end
    end
    g = '0;
    if (found) begin
      blk_used[best] = 1'b1;
      g.granted = 1'b1;
      g.index = idx_t'(best);
      g.bsize = blk_size[best];
      g.frag = rem_best;
    end
    grant_q.push_back(g);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= MaxReports)
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  task automatic check_grant(input grant_t got, input grant_t want);
    if (got.granted !== want.granted)
      report_mismatch("granted", 32'(got.granted), 32'(want.granted));
    if (got.index !== want.index)
      report_mismatch("block_index", 32'(got.index), 32'(want.index));
    if (got.bsize !== want.bsize)
      report_mismatch("block_size", 32'(got.bsize), 32'(want.bsize));
    if (got.frag !== want.frag)
      report_mismatch("fragment", 32'(got.frag), 32'(want.frag));
  endtask

  task automatic push_item(input opcode_e op, input int unsigned entry,
                           input int unsigned sz);
    item_q.push_back('{op, idx_t'(entry), size_t'(sz)});
  endtask

  // sender holds off until every grant has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (item_q.size() != 0 || start || grant_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_blocks(input int unsigned num);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= num_t'(num);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(99) < 40)
        push_item(OpLoad, $urandom_range(31), 32'(pick_size()));
      else
        push_item(OpAlloc, $urandom_range(31), 32'(pick_size()));
    end
    wait_idle();
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || took) begin
        if (item_q.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
          cur_item = item_q.pop_front();
          start <= 1'b1;
          opcode <= cur_item.op;
          entry_index <= cur_item.entry;
          size <= cur_item.size;
        end else begin
          start <= 1'b0;
        end
      end
      took = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      quiet = quiet + 1;
      if (done) begin
        quiet = 0;
        if (grant_q.size() == 0)
          report_mismatch("result with nothing pending", 1, 0);
        else
          check_grant({granted, block_index, block_size, fragment}, grant_q.pop_front());
      end
      if (start && !busy) begin
        quiet = 0;
        took = 1'b1;
        place_item('{opcode, entry_index, size});
      end
      if (cfg_we) num_cfg = cfg_wdata;
      if (quiet >= QuietLimit) begin
        $display("tb_best_fit_block_allocator: errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MaxBlocks; i++) begin
      blk_size[i] = '0;
      blk_used[i] = 1'b0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // empty search after reset, then fill every entry
    push_item(OpAlloc, 0, 0);
    push_item(OpAlloc, 31, 32'hFFFF);
    for (int unsigned e = 0; e < MaxBlocks; e++) begin
      if (e == 0) push_item(OpLoad, e, 0);
      else if (e == 31) push_item(OpLoad, e, 32'hFFFF);
      else if (e == 5 || e == 9) push_item(OpLoad, e, 100);
      else push_item(OpLoad, e, 32'(pick_size()));
    end
    wait_idle();

    // exact fits, refusal, zero-size, tie on lowest index, reload frees
    set_blocks(32);
    push_item(OpAlloc, 7, 32'hFFFF);
    push_item(OpAlloc, 31, 32'hFFFF);
    push_item(OpAlloc, 0, 0);
    push_item(OpAlloc, 3, 100);
    push_item(OpAlloc, 3, 100);
    push_item(OpLoad, 31, 32'hFFFF);
    push_item(OpAlloc, 16, 32'hFFFF);
    wait_idle();

    foreach (plan[k]) begin
      set_blocks(plan[k]);
      calm = (k == 3);
      random_phase(50);
    end
    calm = 1'b0;

    wait_idle();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0)
      $display("tb_best_fit_block_allocator: clean");
    else
      $display("tb_best_fit_block_allocator: errors");
    $finish;
  end

endmodule

// ===== best_fit_block_allocator.f =====
rtl/core/bfa_pkg.sv
rtl/core/bfa_table.sv
rtl/core/best_fit_block_allocator.sv
tb/tb_best_fit_block_allocator.sv
